// ===== rtl/core/owm_pkg.sv =====
// Package for the 1-Wire over UART master: request and result codes,
// slot bytes, register defaults and the result record.
// No dependencies; used by the core and its checker.
package owm_pkg;

  localparam int unsigned BITS_PER_BYTE_DEF = 8;

  localparam logic [7:0] SLOT_ONE    = 8'hFF;
  localparam logic [7:0] SLOT_ZERO   = 8'h00;
  localparam logic [7:0] RESET_PULSE = 8'hF0;

  localparam logic [7:0] RESET_BAUD_DEF = 8'd217;
  localparam logic [7:0] DATA_BAUD_DEF  = 8'd253;

  // Register word index on the configuration port.
  localparam logic REG_RESET_BAUD = 1'b0;
  localparam logic REG_DATA_BAUD  = 1'b1;

  typedef enum logic [1:0] {
    OP_RESET = 2'd0,
    OP_WBYTE = 2'd1,
    OP_WBIT  = 2'd2,
    OP_RX    = 2'd3
  } op_t;

  localparam logic [1:0] KIND_TX         = 2'd0;
  localparam logic [1:0] KIND_RESET_DONE = 2'd1;
  localparam logic [1:0] KIND_WRITE_DONE = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] tx_byte;
    logic [7:0] baud_code;
    logic [7:0] reply;
  } result_t;

  function automatic logic [7:0] slot_byte(input logic bit_value);
    return bit_value ? SLOT_ONE : SLOT_ZERO;
  endfunction

endpackage

// ===== rtl/core/onewire_over_uart_master_unit.sv =====
// 1-Wire bus master sequenced through a byte UART: request decode, slot
// sequencing, echo decoding and a skid-buffered result register.
// Depends on owm_pkg.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+--------------------------------------
//  in       | in_valid / in_stall      | op, data
//  out      | out_valid / out_stall    | kind, tx_byte, baud_code, reply
//  config   | psel penable pwrite ...  | paddr, pwdata, prdata (APB write/read)
//
// One item is taken every cycle while in_stall is low; its result, if any, shows on the output
// register in the cycle after the transfer when that register is free.
// The sequencing state updates on each accepted item, which sets this rate.
// A skid register takes one result while out_stall holds the output;
// in_stall rises only while the skid register is full.
// Reset clears the sequencing state and both buffer valid flags and restores the baud codes.
module onewire_over_uart_master_unit #(
  parameter int unsigned BITS_PER_BYTE = owm_pkg::BITS_PER_BYTE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [7:0]  data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [7:0]  tx_byte,
  output logic [7:0]  baud_code,
  output logic [7:0]  reply,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import owm_pkg::*;

  localparam int unsigned CNT_W = $clog2(BITS_PER_BYTE + 1);

  typedef enum logic [1:0] {
    P_IDLE  = 2'd0,
    P_RESET = 2'd1,
    P_WBYTE = 2'd2,
    P_WBIT  = 2'd3
  } pend_t;

  pend_t            pending;
  pend_t            pending_next;
  logic [CNT_W-1:0] slots_sent;
  logic [CNT_W-1:0] slots_sent_next;
  logic [7:0]       bits_to_send;
  logic [7:0]       bits_to_send_next;
  logic [7:0]       echo_bits;
  logic [7:0]       echo_bits_next;
  logic [7:0]       reset_baud;
  logic [7:0]       data_baud;

  result_t          res;
  logic             res_valid;
  result_t          out_res;
  result_t          skid_res;
  logic             skid_valid;

  logic             in_fire;
  logic             cfg_write;
  logic [2:0]       slot_idx;
  logic [2:0]       echo_idx;
  logic [7:0]       echo_upd;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_DATA_BAUD) ? 32'(data_baud) : 32'(reset_baud);

  assign in_stall = skid_valid;
  assign in_fire  = in_valid && !in_stall;

  assign slot_idx = 3'(slots_sent);
  assign echo_idx = 3'(slots_sent - 1'b1);
  assign echo_upd = echo_bits | (8'(data == SLOT_ONE) << echo_idx);

  always_comb begin
    pending_next      = pending;
    slots_sent_next   = slots_sent;
    bits_to_send_next = bits_to_send;
    echo_bits_next    = echo_bits;
    res               = '0;
    res_valid         = 1'b0;
    unique case (op_t'(op))
      OP_RESET: begin
        pending_next  = P_RESET;
        res_valid     = 1'b1;
        res.kind      = KIND_TX;
        res.tx_byte   = RESET_PULSE;
        res.baud_code = reset_baud;
      end
      OP_WBYTE: begin
        pending_next      = P_WBYTE;
        bits_to_send_next = data;
        echo_bits_next    = '0;
        slots_sent_next   = CNT_W'(1);
        res_valid         = 1'b1;
        res.kind          = KIND_TX;
        res.tx_byte       = slot_byte(data[0]);
        res.baud_code     = data_baud;
      end
      OP_WBIT: begin
        pending_next  = P_WBIT;
        res_valid     = 1'b1;
        res.kind      = KIND_TX;
        res.tx_byte   = slot_byte(data[0]);
        res.baud_code = data_baud;
      end
      OP_RX: begin
        unique case (pending)
          P_RESET: begin
            pending_next = P_IDLE;
            res_valid    = 1'b1;
            res.kind     = KIND_RESET_DONE;
            res.reply    = data;
          end
          P_WBIT: begin
            pending_next = P_IDLE;
            res_valid    = 1'b1;
            res.kind     = KIND_WRITE_DONE;
            res.reply    = data;
          end
          P_WBYTE: begin
            echo_bits_next = echo_upd;
            res_valid      = 1'b1;
            if (slots_sent >= CNT_W'(BITS_PER_BYTE)) begin
              pending_next = P_IDLE;
              res.kind     = KIND_WRITE_DONE;
              res.reply    = echo_upd;
            end else begin
              res.kind        = KIND_TX;
              res.tx_byte     = slot_byte(bits_to_send[slot_idx]);
              res.baud_code   = data_baud;
              slots_sent_next = slots_sent + 1'b1;
            end
          end
          default: begin
            // An echo with nothing in progress is dropped.
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending      <= P_IDLE;
      slots_sent   <= '0;
      bits_to_send <= '0;
      echo_bits    <= '0;
      reset_baud   <= RESET_BAUD_DEF;
      data_baud    <= DATA_BAUD_DEF;
      out_valid    <= 1'b0;
      skid_valid   <= 1'b0;
    end else begin
      if (cfg_write) begin
        if (paddr[2] == REG_DATA_BAUD) begin
          data_baud <= pwdata[7:0];
        end else begin
          reset_baud <= pwdata[7:0];
        end
      end
      if (in_fire) begin
        pending      <= pending_next;
        slots_sent   <= slots_sent_next;
        bits_to_send <= bits_to_send_next;
        echo_bits    <= echo_bits_next;
      end
      // The output register refills from the skid register first; no new
      // item is taken while the skid register is full.
      if (!out_valid || !out_stall) begin
        if (skid_valid) begin
          out_res    <= skid_res;
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_res   <= res;
          out_valid <= in_fire && res_valid;
        end
      end else if (in_fire && res_valid) begin
        skid_res   <= res;
        skid_valid <= 1'b1;
      end
    end
  end

  assign kind      = out_res.kind;
  assign tx_byte   = out_res.tx_byte;
  assign baud_code = out_res.baud_code;
  assign reply     = out_res.reply;

endmodule

// ===== rtl/core/owm_checker.sv =====
// Port-level checker for the 1-Wire over UART master, with its bind.
// Depends on owm_pkg and onewire_over_uart_master_unit.
module owm_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [1:0] op,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] kind,
  input logic [7:0] tx_byte,
  input logic [7:0] baud_code,
  input logic [7:0] reply
);
  import owm_pkg::*;

  // A held result keeps its payload until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(tx_byte)
      && $stable(baud_code) && $stable(reply))
    else $error("output payload changed while stalled");

  // Transmit results carry no reply; completions carry no byte or baud code.
  a_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (kind == KIND_TX && reply == 8'h00)
      || ((kind == KIND_RESET_DONE || kind == KIND_WRITE_DONE)
          && tx_byte == 8'h00 && baud_code == 8'h00))
    else $error("result fields inconsistent with kind");

  // A reset request into an empty output shows the reset pulse next cycle.
  a_reset_pulse: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && op == OP_RESET && !out_valid
      |=> out_valid && kind == KIND_TX && tx_byte == RESET_PULSE)
    else $error("reset request did not produce the reset pulse");

  // Input backpressure appears only while a result is being held.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("input stalled without a held result");

endmodule

bind onewire_over_uart_master_unit owm_checker u_owm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .op        (op),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .kind      (kind),
  .tx_byte   (tx_byte),
  .baud_code (baud_code),
  .reply     (reply)
);

// ===== tb/owm_result_predictor_pkg.sv =====
// Result predictor and scoreboard for the 1-Wire over UART master testbench.
// Tracks the sequencing state and baud codes and queues the results each transfer causes.
// Depends on owm_pkg for the request, result and slot codes.
package owm_result_predictor_pkg;
  import owm_pkg::*;

  localparam int unsigned SLOT_COUNT = BITS_PER_BYTE_DEF;

  typedef enum logic [1:0] {
    BUSY_NONE  = 2'd0,
    BUSY_RESET = 2'd1,
    BUSY_WBYTE = 2'd2,
    BUSY_WBIT  = 2'd3
  } busy_t;

  class owm_result_predictor;
    logic [7:0] reset_baud;
    logic [7:0] data_baud;
    busy_t      busy;
    logic [3:0] slots_sent;
    logic [7:0] byte_out;
    logic [7:0] echo_bits;
    result_t    awaited[$];
    int         errors;
    int         requests;
    int         results;

    function new();
      reset_baud = RESET_BAUD_DEF;
      data_baud  = DATA_BAUD_DEF;
      busy       = BUSY_NONE;
      slots_sent = '0;
      byte_out   = '0;
      echo_bits  = '0;
      errors     = 0;
      requests   = 0;
      results    = 0;
    endfunction

    function void set_baud(logic [7:0] reset_code, logic [7:0] data_code);
      reset_baud = reset_code;
      data_baud  = data_code;
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction

    // Advances the sequencer by one accepted transfer and queues its result, if any.
    function void note_request(op_t op_code, logic [7:0] value);
      result_t    r;
      logic [2:0] idx;
      bit         produces;
      r = '0;
      produces = 1'b1;
      requests++;
      case (op_code)
        OP_RESET: begin
          busy = BUSY_RESET;
          r.kind = KIND_TX;
          r.tx_byte = RESET_PULSE;
          r.baud_code = reset_baud;
        end
        OP_WBYTE: begin
          busy = BUSY_WBYTE;
          byte_out = value;
          echo_bits = '0;
          slots_sent = 4'd1;
          r.kind = KIND_TX;
          r.tx_byte = value[0] ? SLOT_ONE : SLOT_ZERO;
          r.baud_code = data_baud;
        end
        OP_WBIT: begin
          busy = BUSY_WBIT;
          r.kind = KIND_TX;
          r.tx_byte = value[0] ? SLOT_ONE : SLOT_ZERO;
          r.baud_code = data_baud;
        end
        default: begin
          case (busy)
            BUSY_RESET: begin
              busy = BUSY_NONE;
              r.kind = KIND_RESET_DONE;
              r.reply = value;
            end
            BUSY_WBIT: begin
              busy = BUSY_NONE;
              r.kind = KIND_WRITE_DONE;
              r.reply = value;
            end
            BUSY_WBYTE: begin
              idx = (slots_sent == 4'd0) ? 3'd0 : 3'(slots_sent - 4'd1);
              // Only an exact all-ones echo reads back as a one.
              if (value == SLOT_ONE) echo_bits[idx] = 1'b1;
              if (slots_sent >= SLOT_COUNT) begin
                busy = BUSY_NONE;
                r.kind = KIND_WRITE_DONE;
                r.reply = echo_bits;
              end else begin
                r.kind = KIND_TX;
                r.tx_byte = byte_out[slots_sent[2:0]] ? SLOT_ONE : SLOT_ZERO;
                r.baud_code = data_baud;
                slots_sent = slots_sent + 4'd1;
              end
            end
            default: produces = 1'b0;
          endcase
        end
      endcase
      if (produces) awaited.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (awaited.size() == 0) begin
        $error("unexpected result: kind %0d tx_byte %02h baud_code %02h reply %02h",
               got.kind, got.tx_byte, got.baud_code, got.reply);
        errors++;
        return;
      end
      want = awaited.pop_front();
      results++;
      if (got.kind !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, got.kind);
        errors++;
      end
      if (got.tx_byte !== want.tx_byte) begin
        $error("tx_byte: expected %02h, got %02h", want.tx_byte, got.tx_byte);
        errors++;
      end
      if (got.baud_code !== want.baud_code) begin
        $error("baud_code: expected %02h, got %02h", want.baud_code, got.baud_code);
        errors++;
      end
      if (got.reply !== want.reply) begin
        $error("reply: expected %02h, got %02h", want.reply, got.reply);
        errors++;
      end
    endfunction
  endclass

endpackage

// ===== tb/onewire_over_uart_master_unit_tb.sv =====
// Testbench top for onewire_over_uart_master_unit: drives requests and echoes,
// programs the baud codes over APB and checks every result transfer.
// Depends on owm_pkg and owm_result_predictor_pkg.
module onewire_over_uart_master_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import owm_pkg::*;
  import owm_result_predictor_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int ITEMS_PER_PHASE = 270;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  op;
  logic [7:0]  data;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  kind;
  logic [7:0]  tx_byte;
  logic [7:0]  baud_code;
  logic [7:0]  reply;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int idle_cycles = 0;
  int baud_settings = 1;

  owm_result_predictor sb = new();

  onewire_over_uart_master_unit DUT (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  always @(negedge clk) begin
    out_stall <= rst ? 1'b0 : ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_result('{kind: kind, tx_byte: tx_byte, baud_code: baud_code, reply: reply});
    end
  end

  // The watchdog restarts on every transfer on either channel.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d cycles without a transfer", idle_cycles);
      $display("onewire_over_uart_master_unit_tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(op_t op_code, logic [7:0] value);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    op <= op_code;
    data <= value;
    do @(posedge clk); while (in_stall);
    sb.note_request(op_code, value);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.outstanding() != 0);
  endtask

  task automatic apb_access(logic is_write, logic reg_index, logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= is_write;
    paddr <= {reg_index, 2'b00};
    pwdata <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic check_registers();
    logic [31:0] rd;
    apb_access(1'b0, REG_RESET_BAUD, '0, rd);
    if (rd !== {24'd0, sb.reset_baud}) begin
      $error("reset_baud_code: expected %02h, got %08h", sb.reset_baud, rd);
      sb.errors++;
    end
    apb_access(1'b0, REG_DATA_BAUD, '0, rd);
    if (rd !== {24'd0, sb.data_baud}) begin
      $error("data_baud_code: expected %02h, got %08h", sb.data_baud, rd);
      sb.errors++;
    end
  endtask

  // Registers change only once every expected result is out and the block has settled.
  task automatic set_baud_codes(logic [7:0] reset_code, logic [7:0] data_code);
    logic [31:0] rd;
    drain_results();
    repeat (4) @(negedge clk);
    apb_access(1'b1, REG_RESET_BAUD, {24'd0, reset_code}, rd);
    apb_access(1'b1, REG_DATA_BAUD, {24'd0, data_code}, rd);
    sb.set_baud(reset_code, data_code);
    baud_settings++;
    check_registers();
  endtask

  // Mostly the slot that was sent, sometimes all ones, a slave pulling low or line noise.
  function automatic logic [7:0] echo_for(logic [7:0] sent);
    case ($urandom_range(9))
      7: return SLOT_ZERO;
      8: return 8'($urandom);
      9: return SLOT_ONE;
      default: return sent;
    endcase
  endfunction

  task automatic random_transaction();
    logic [7:0] b;
    int         n;
    int         pick;
    pick = $urandom_range(99);
    b = 8'($urandom);
    if (pick < 10) begin
      send_item(op_t'($urandom_range(3)), b);
    end else if (pick < 35) begin
      send_item(OP_RESET, b);
      if ($urandom_range(9) != 0) send_item(OP_RX, echo_for(RESET_PULSE));
    end else if (pick < 80) begin
      send_item(OP_WBYTE, b);
      // A few writes are cut short, leaving a request to be overridden.
      n = ($urandom_range(9) == 0) ? $urandom_range(7) : SLOT_COUNT;
      for (int i = 0; i < n; i++) begin
        send_item(OP_RX, echo_for(b[i] ? SLOT_ONE : SLOT_ZERO));
      end
    end else begin
      send_item(OP_WBIT, b);
      if ($urandom_range(9) != 0) send_item(OP_RX, echo_for(b[0] ? SLOT_ONE : SLOT_ZERO));
    end
  endtask

  initial begin
    int phase_end;
    in_valid = 1'b0;
    op = OP_RESET;
    data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    @(negedge clk);
    while (rst) @(negedge clk);

    check_registers();

    // Directed sequences at the reset baud codes, with no idling.
    send_item(OP_RESET, 8'hFF);
    send_item(OP_RX, 8'h00);
    send_item(OP_RX, 8'hFF);
    send_item(OP_WBYTE, 8'hA5);
    send_item(OP_RX, 8'hFF);
    send_item(OP_RX, 8'h00);
    send_item(OP_RX, 8'hFF);
    send_item(OP_RX, 8'h00);
    send_item(OP_RX, 8'h00);
    send_item(OP_RX, 8'hFE);
    send_item(OP_RX, 8'h7F);
    send_item(OP_RX, 8'hFF);
    send_item(OP_WBIT, 8'hFE);
    send_item(OP_RX, 8'hF3);
    send_item(OP_WBIT, 8'h01);
    send_item(OP_RESET, 8'h00);
    send_item(OP_RX, 8'hE0);
    send_item(OP_WBYTE, 8'h00);
    send_item(OP_RX, 8'h00);
    send_item(OP_WBIT, 8'h01);
    send_item(OP_RX, 8'hFF);
    send_item(OP_RX, 8'h55);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        1: set_baud_codes(8'h00, 8'hFF);
        2: set_baud_codes(8'hFF, 8'h00);
        3: set_baud_codes(8'($urandom), 8'($urandom));
        default: ;
      endcase
      send_idle_pct = (phase == 1) ? 75 : (phase == 3) ? 15 : 0;
      stall_pct = (phase == 2) ? 75 : (phase == 3) ? 15 : 0;
      phase_end = sb.requests + ITEMS_PER_PHASE;
      while (sb.requests < phase_end) begin
        random_transaction();
        case ($urandom_range(59))
          0: set_baud_codes(8'($urandom), 8'($urandom));
          1: drain_results();
          default: ;
        endcase
      end
    end

    drain_results();
    repeat (10) @(posedge clk);
    $display("Checked %0d result transfers from %0d accepted requests and echoes,",
             sb.results, sb.requests);
    $display("across four idle/stall mixes and %0d baud code settings.", baud_settings);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("onewire_over_uart_master_unit_tb: PASS");
    end else begin
      $display("onewire_over_uart_master_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
